// ===== sv/msr_pkg.sv =====
// Package for the masked scaled softmax row block: widths, register
// indices, reset values and the exp lookup tables. No dependencies.
package msr_pkg;

    localparam int MAX_COLS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int CNT_W    = COL_W + 1;
    localparam int SUM_W    = 23;
    localparam int QUOT_W   = 17;
    localparam int DVD_W    = 33;
    localparam int STEP_W   = 5;

    localparam logic REG_SCALE  = 1'b0;
    localparam logic REG_CAUSAL = 1'b1;

    localparam logic [15:0] SCALE_RST = 16'd4096;
    localparam logic [15:0] MAX_RST   = 16'h8000;

    typedef logic [15:0] t_word;

    // exp(-k) for integer part k, Q1.16 with 65536 = 1.0
    function automatic logic [16:0] exp_int_f(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-k/16)
    function automatic logic [16:0] exp_hi_f(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57836;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

    // exp(-k/256)
    function automatic logic [16:0] exp_lo_f(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd65280;
            4'd2:    v = 17'd65026;
            4'd3:    v = 17'd64772;
            4'd4:    v = 17'd64520;
            4'd5:    v = 17'd64268;
            4'd6:    v = 17'd64018;
            4'd7:    v = 17'd63768;
            4'd8:    v = 17'd63520;
            4'd9:    v = 17'd63272;
            4'd10:   v = 17'd63025;
            4'd11:   v = 17'd62780;
            4'd12:   v = 17'd62535;
            4'd13:   v = 17'd62291;
            4'd14:   v = 17'd62048;
            default: v = 17'd61806;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/msr_div.sv =====
// Restoring divider, one quotient bit per cycle, for the normalize pass.
// Depends on msr_pkg.
module msr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [msr_pkg::DVD_W-1:0]  i_dividend,
    input  logic [msr_pkg::SUM_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [msr_pkg::QUOT_W-1:0] o_quot
);
    import msr_pkg::*;

    logic [SUM_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_q;
    logic [STEP_W-1:0] r_cnt;
    logic              r_done;
    logic [SUM_W:0]    trial;
    logic              ge;

    assign trial = {r_rem, r_q[QUOT_W-1]};
    assign ge    = trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= STEP_W'(QUOT_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) r_done <= 1'b1;
            end
        end
    end

    // quotient is known to fit QUOT_W bits, so the top part starts below divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= SUM_W'(i_dividend[DVD_W-1:QUOT_W]);
            r_q   <= i_dividend[QUOT_W-1:0];
        end else if (r_cnt != '0) begin
            r_rem <= ge ? SUM_W'(trial - {1'b0, i_divisor}) : trial[SUM_W-1:0];
            r_q   <= {r_q[QUOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== sv/masked_scaled_softmax_row.sv =====
// Top level of the masked scaled softmax row block: load, exp and normalize
// sequencer with row and exp memories. Depends on msr_pkg and msr_div.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata{row_index,score}, tlast=last_in_row
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata{probability}, tlast=last_out
//  apb       in   psel & penable & pwrite         0x0 score_scale, 0x4 causal_enable
//
// Each score is loaded as it is accepted (scale multiply, mask and max update).
// On the last item of a row the exp pass takes each column through the
// shared two-step table multiply, then the normalize pass runs each column
// through the bit-serial 17-step divider and then waits on any output
// stall. s_axis_tready is low from the last item until the final
// probability is taken. Reset is synchronous, active low; memories are not
// cleared, only written columns are read.
module masked_scaled_softmax_row (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] score, [31:16] row_index
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] probability
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import msr_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_E_RD  = 4'd1;
    localparam logic [3:0] S_E_M1  = 4'd2;
    localparam logic [3:0] S_E_M2  = 4'd3;
    localparam logic [3:0] S_E_WR  = 4'd4;
    localparam logic [3:0] S_N_RD  = 4'd5;
    localparam logic [3:0] S_N_LD  = 4'd6;
    localparam logic [3:0] S_N_DIV = 4'd7;
    localparam logic [3:0] S_N_OUT = 4'd8;

    // config registers
    logic [15:0] r_scale;
    logic        r_causal;
    logic        cfg_wr;

    // control state
    logic [3:0]       r_state;
    logic [CNT_W-1:0] r_count;
    logic [COL_W-1:0] r_col;
    t_word            r_max;
    logic [SUM_W-1:0] r_sum;

    // memories: {mask, scaled score} per column, and exp per column
    logic [16:0] r_row_mem [MAX_COLS];
    logic [15:0] r_exp_mem [MAX_COLS];
    logic [16:0] r_row_rd;
    logic [15:0] r_exp_rd;

    // datapath registers
    logic [16:0] r_m1;
    logic [16:0] r_m2;
    logic [3:0]  r_dlo;
    logic        r_zero;
    logic [15:0] r_prob;

    // load-side arithmetic
    logic signed [15:0] in_score;
    logic [15:0]        in_row;
    logic signed [32:0] prod;
    logic signed [32:0] shifted;
    t_word              scaled;
    logic               in_mask;
    logic               in_acc;

    // exp-side arithmetic
    t_word       diff;
    logic [33:0] m1_full;
    logic [33:0] m2_full;
    logic [15:0] exp_val;
    logic [SUM_W-1:0] sum_eff;
    logic [DVD_W-1:0] dividend;
    logic              div_start;
    logic              div_done;
    logic [QUOT_W-1:0] quot;
    logic              col_last;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_RST;
            r_causal <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_SCALE:  r_scale  <= pwdata[15:0];
                REG_CAUSAL: r_causal <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SCALE:  prdata = {16'd0, r_scale};
            REG_CAUSAL: prdata = {31'd0, r_causal};
            default:    prdata = '0;
        endcase
    end

    // Load: Q8.8 * Q4.12, round half up, saturate
    assign in_score = $signed(s_axis_tdata[15:0]);
    assign in_row   = s_axis_tdata[31:16];
    assign prod     = in_score * $signed({1'b0, r_scale});
    assign shifted  = (prod + 33'sd2048) >>> 12;

    always_comb begin
        if (shifted > 33'sd32767)       scaled = 16'h7FFF;
        else if (shifted < -33'sd32768) scaled = 16'h8000;
        else                            scaled = shifted[15:0];
    end

    assign in_mask = r_causal && (16'(r_count) > in_row);
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc = s_axis_tvalid & s_axis_tready;

    // Exp: two table products with a register between them
    assign diff    = r_max - r_row_rd[15:0];
    assign m1_full = exp_int_f(diff[11:8]) * exp_hi_f(diff[7:4]) + 34'd32768;
    assign m2_full = r_m1 * exp_lo_f(r_dlo) + 34'd32768;
    assign exp_val = r_zero ? 16'd0 : ((r_m2[16]) ? 16'hFFFF : r_m2[15:0]);

    // Normalize: (e * 65536 + sum/2) / sum with a zero sum taken as one
    assign sum_eff   = (r_sum == '0) ? SUM_W'(1) : r_sum;
    assign dividend  = {1'b0, r_exp_rd, 16'd0} + DVD_W'(sum_eff >> 1);
    assign div_start = (r_state == S_N_LD);
    assign col_last  = (CNT_W'(r_col) == r_count - 1'b1);

    msr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (sum_eff),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc && r_count < CNT_W'(MAX_COLS)) begin
            r_row_mem[r_count[COL_W-1:0]] <= {in_mask, scaled};
        end
        if (r_state == S_E_WR) r_exp_mem[r_col] <= exp_val;
        r_row_rd <= r_row_mem[r_col];
        r_exp_rd <= r_exp_mem[r_col];
    end

    always_ff @(posedge i_clk) begin
        r_m1   <= m1_full[32:16];
        r_dlo  <= diff[3:0];
        r_m2   <= m2_full[32:16];
        if (r_state == S_E_M1) r_zero <= r_row_rd[16] | (diff[15:8] >= 8'd12);
        if (div_done) r_prob <= quot[16] ? 16'hFFFF : quot[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_col   <= '0;
            r_max   <= MAX_RST;
            r_sum   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (r_count < CNT_W'(MAX_COLS)) begin
                            r_count <= r_count + 1'b1;
                            if (!in_mask && $signed(scaled) > $signed(r_max)) r_max <= scaled;
                        end
                        if (s_axis_tlast) begin
                            r_col   <= '0;
                            r_sum   <= '0;
                            r_state <= S_E_RD;
                        end
                    end
                end
                S_E_RD: r_state <= S_E_M1;
                S_E_M1: r_state <= S_E_M2;
                S_E_M2: r_state <= S_E_WR;
                S_E_WR: begin
                    r_sum <= r_sum + SUM_W'(exp_val);
                    if (col_last) begin
                        r_col   <= '0;
                        r_state <= S_N_RD;
                    end else begin
                        r_col   <= r_col + 1'b1;
                        r_state <= S_E_RD;
                    end
                end
                S_N_RD: r_state <= S_N_LD;
                S_N_LD: r_state <= S_N_DIV;
                S_N_DIV: begin
                    if (div_done) r_state <= S_N_OUT;
                end
                S_N_OUT: begin
                    if (m_axis_tready) begin
                        if (col_last) begin
                            r_count <= '0;
                            r_max   <= MAX_RST;
                            r_sum   <= '0;
                            r_col   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_col   <= r_col + 1'b1;
                            r_state <= S_N_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = (r_state == S_N_OUT);
    assign m_axis_tdata  = r_prob;
    assign m_axis_tlast  = col_last;

endmodule
